[rtl/core/odu_pkg.sv]
// shared types and constants for the order preserving dedup unit
package odu_pkg;

    localparam int VALUE_W = 32;

    // element travelling down the compare chain
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      hit;     // matched a stored entry
        logic                      stored;  // written into some cell
    } item_t;

endpackage

[rtl/core/odu_cell.sv]
// one compare cell: holds one table entry and one pipeline slot
module odu_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic          in_valid,
    input  odu_pkg::item_t in_item,
    output logic          out_valid,
    output odu_pkg::item_t out_item
);

    logic                              entry_valid_reg;
    logic                              entry_valid_next;
    logic signed [odu_pkg::VALUE_W-1:0] entry_value_reg;
    logic signed [odu_pkg::VALUE_W-1:0] entry_value_next;
    logic                              out_valid_reg;
    odu_pkg::item_t                    out_item_reg;
    odu_pkg::item_t                    out_item_next;
    logic                              match;
    logic                              pending;

    assign match   = entry_valid_reg && (entry_value_reg == in_item.value);
    assign pending = in_valid && !in_item.hit && !in_item.stored;

    always_comb begin
        entry_valid_next = entry_valid_reg;
        entry_value_next = entry_value_reg;
        out_item_next    = in_item;
        if (pending) begin
            if (match) begin
                out_item_next.hit = 1'b1;
            end else if (!entry_valid_reg) begin
                // first free cell takes the new value
                entry_valid_next     = 1'b1;
                entry_value_next     = in_item.value;
                out_item_next.stored = 1'b1;
            end
        end
        // end of set empties the entry once the last element has passed
        if (in_valid && in_item.last) begin
            entry_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (advance) begin
            entry_valid_reg <= entry_valid_next;
            out_valid_reg   <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_value_reg <= entry_value_next;
            out_item_reg    <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[rtl/core/order_preserving_dedup_unit.sv]
// top level of the order preserving dedup unit: a chain of compare cells
//
// input channel s_*: one element per beat, s_last marks the final element of a set
// output channel m_*: one beat per input beat, same order, with m_keep set on the
//   first occurrence of a value in the set and m_full_res set when a new value
//   found no free table entry (it is still kept, but not remembered)
// the table lives in a row of CAPACITY cells; every element walks the row one
//   cell per cycle while the row advances, claims the first free cell if no cell
//   matched, and the last element of a set empties each cell as it passes it
// from input beat to output valid an element is registered in every cell of the row
// throughput: one element per cycle while the row advances; a new element may
//   enter every cycle, reaching each cell after its predecessor updated that cell
// the final cell's slot is the output register; when the receiver stalls the whole
//   row holds and s_ready drops, and nothing is lost
// reset: all cells empty, no element in flight, m_valid low
module order_preserving_dedup_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [odu_pkg::VALUE_W-1:0] s_value,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [odu_pkg::VALUE_W-1:0] m_value_out,
    output logic                              m_keep,
    output logic                              m_full_res,
    output logic                              m_last_out
);

    // stage k feeds cell k; stage CAPACITY is the output slot
    logic           stage_valid [CAPACITY+1];
    odu_pkg::item_t stage_item  [CAPACITY+1];
    logic           advance;

    // the row moves whenever the output slot is empty or being taken
    assign advance = !stage_valid[CAPACITY] || m_ready;
    assign s_ready = advance;

    assign stage_valid[0]       = s_valid;
    assign stage_item[0].value  = s_value;
    assign stage_item[0].last   = s_last;
    assign stage_item[0].hit    = 1'b0;
    assign stage_item[0].stored = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        odu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (stage_valid[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    // an element that neither matched nor found a free cell is new but unstored
    assign m_valid     = stage_valid[CAPACITY];
    assign m_value_out = stage_item[CAPACITY].value;
    assign m_keep      = !stage_item[CAPACITY].hit;
    assign m_full_res  = !stage_item[CAPACITY].hit && !stage_item[CAPACITY].stored;
    assign m_last_out  = stage_item[CAPACITY].last;

endmodule

[rtl/core/odu_checker.sv]
// port level checks for the order preserving dedup unit, bound to the top level
module odu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [odu_pkg::VALUE_W-1:0] m_value_out,
    input logic                              m_keep,
    input logic                              m_full_res,
    input logic                              m_last_out
);

    // a value flagged as unstorable is always a new value
    a_full_implies_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_res |-> m_keep)
        else $error("full_res without keep");

    // a free or draining output slot lets the row move
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");

    // reset leaves nothing in flight
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_keep)
            && $stable(m_full_res) && $stable(m_last_out))
        else $error("result beat changed while stalled");

    // a stall at the output backs up to the input
    a_stall_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output slot is blocked");

endmodule

bind order_preserving_dedup_unit odu_checker u_odu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value_out (m_value_out),
    .m_keep      (m_keep),
    .m_full_res  (m_full_res),
    .m_last_out  (m_last_out)
);
